[src/fbpm_pkg.sv]
// Shared types and constants of the fixed block pool manager.
// Used by fbpm_ctrl and by the top level fixed_block_pool_manager.
package fbpm_pkg;

	localparam int NUM_CFG    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_W      = 7;
	localparam int KIND_W     = 3;
	localparam int POOL_ID_W  = 4;
	localparam int TASK_W     = 8;
	localparam int BLOCK_W    = 6;
	localparam int COUNT_W    = 7;
	localparam int STATUS_W   = 3;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [KIND_W-1:0] {
		KIND_GET_WAIT = 3'd0,
		KIND_GET_POLL = 3'd1,
		KIND_RELEASE  = 3'd2,
		KIND_REFER    = 3'd3,
		KIND_INIT     = 3'd4
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK         = 3'd0,
		STATUS_BAD_ID     = 3'd1,
		STATUS_NO_POOL    = 3'd2,
		STATUS_WRONG_CTX  = 3'd3,
		STATUS_EMPTY      = 3'd4,
		STATUS_QUEUED     = 3'd5,
		STATUS_WAITQ_FULL = 3'd6,
		STATUS_OVERFLOW   = 3'd7
	} status_t;

	// Result of one word before the RAM read data is merged in.
	typedef struct packed {
		status_t             status;
		logic [BLOCK_W-1:0]  granted;
		logic [COUNT_W-1:0]  free_count;
		logic                stack_rd;   // granted comes from the stack RAM
		logic                woken_rd;   // woken task comes from the waiter RAM
		logic                head_rd;    // head waiter comes from the waiter RAM
	} item_res_t;

	typedef struct packed {
		logic stack_we;
		logic stack_re;
		logic fifo_we;
		logic fifo_re;
	} mem_ctl_t;

endpackage

[src/fbpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the stack and waiter stores.
module fbpm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/fbpm_ctrl.sv]
// Per-pool counters and the decision logic for one accepted word.
// Depends on fbpm_pkg; drives the stack and waiter RAM ports of the top level.
module fbpm_ctrl #(
	parameter int NUM_POOLS   = 4,
	parameter int MAX_BLOCKS  = 64,
	parameter int MAX_WAITERS = 8,
	parameter int MAX_TASKS   = 255,
	localparam int PW  = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1,
	localparam int BW  = $clog2(MAX_BLOCKS),
	localparam int WW  = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              accept,
	input  logic [fbpm_pkg::KIND_W-1:0]                       kind,
	input  logic [fbpm_pkg::POOL_ID_W-1:0]                    pool_id,
	input  logic [fbpm_pkg::TASK_W-1:0]                       requester_task,
	input  logic [fbpm_pkg::BLOCK_W-1:0]                      released_block,
	input  logic                                              in_task_context,
	input  logic [fbpm_pkg::NUM_CFG-1:0][fbpm_pkg::CFG_W-1:0] pool_blocks,
	output fbpm_pkg::item_res_t                               res,
	output fbpm_pkg::mem_ctl_t                                mem,
	output logic [PW+BW-1:0]                                  stack_addr,
	output logic [PW+WW-1:0]                                  fifo_addr
);

	localparam int CW  = $clog2(MAX_BLOCKS + 1);
	localparam int WCW = $clog2(MAX_WAITERS + 1);
	localparam int XW  = ((CW > fbpm_pkg::CFG_W) ? CW : fbpm_pkg::CFG_W) + 1;

	logic [CW-1:0]  depth_q [NUM_POOLS];
	logic [CW-1:0]  fresh_q [NUM_POOLS];
	logic [WW-1:0]  head_q  [NUM_POOLS];
	logic [WW-1:0]  tail_q  [NUM_POOLS];
	logic [WCW-1:0] count_q [NUM_POOLS];

	logic [CW-1:0]  depth_nx, fresh_nx;
	logic [WW-1:0]  head_nx, tail_nx;
	logic [WCW-1:0] count_nx;
	logic           upd;
	logic           init_all;

	always_comb begin
		logic [fbpm_pkg::POOL_ID_W-1:0] pid_m1;
		logic [fbpm_pkg::CFG_W-1:0]     n_raw, n;
		logic                           id_ok;
		logic [PW-1:0]                  pidx;
		logic [CW-1:0]                  depth, fresh;
		logic [WW-1:0]                  whead, wtail;
		logic [WCW-1:0]                 wcount;
		logic [XW-1:0]                  n_x, fresh_left, free_now;

		pid_m1 = pool_id - 4'd1;
		n_raw  = (32'(pid_m1) < fbpm_pkg::NUM_CFG) ?
			pool_blocks[pid_m1[fbpm_pkg::CFG_IDX_W-1:0]] : '0;
		n      = (9'(n_raw) > 9'(MAX_BLOCKS)) ? fbpm_pkg::CFG_W'(MAX_BLOCKS) : n_raw;
		id_ok  = (pool_id != '0) && (5'(pool_id) <= 5'(NUM_POOLS));
		pidx   = id_ok ? pid_m1[PW-1:0] : '0;

		depth  = depth_q[pidx];
		fresh  = fresh_q[pidx];
		whead  = head_q[pidx];
		wtail  = tail_q[pidx];
		wcount = count_q[pidx];

		n_x        = XW'(n);
		fresh_left = (XW'(fresh) < n_x) ? n_x - XW'(fresh) : '0;
		free_now   = XW'(depth) + fresh_left;

		res        = '0;
		res.status = fbpm_pkg::STATUS_OK;
		mem        = '0;
		stack_addr = {pidx, BW'(depth)};
		fifo_addr  = {pidx, whead};
		depth_nx   = depth;
		fresh_nx   = fresh;
		head_nx    = whead;
		tail_nx    = wtail;
		count_nx   = wcount;
		upd        = 1'b0;
		init_all   = 1'b0;

		priority if (kind == fbpm_pkg::KIND_INIT) begin
			init_all = 1'b1;
		end else if (kind > fbpm_pkg::KIND_INIT) begin
			// no result and no state change
			init_all = 1'b0;
		end else if (pool_id == '0) begin
			res.status = fbpm_pkg::STATUS_BAD_ID;
		end else if (!id_ok || n == '0) begin
			res.status = fbpm_pkg::STATUS_NO_POOL;
		end else if (kind == fbpm_pkg::KIND_GET_WAIT && !in_task_context) begin
			res.status = fbpm_pkg::STATUS_WRONG_CTX;
		end else if (kind == fbpm_pkg::KIND_GET_WAIT || kind == fbpm_pkg::KIND_GET_POLL) begin
			priority if (depth != '0) begin
				// pop the most recently released block
				depth_nx     = depth - CW'(1);
				stack_addr   = {pidx, BW'(depth_nx)};
				mem.stack_re = 1'b1;
				res.stack_rd = 1'b1;
				upd          = 1'b1;
			end else if (fresh_left != '0) begin
				res.granted = fbpm_pkg::BLOCK_W'(fresh);
				fresh_nx    = fresh + CW'(1);
				upd         = 1'b1;
			end else if (kind == fbpm_pkg::KIND_GET_POLL) begin
				res.status = fbpm_pkg::STATUS_EMPTY;
			end else if (requester_task == '0 || 9'(requester_task) > 9'(MAX_TASKS)) begin
				res.status = fbpm_pkg::STATUS_BAD_ID;
			end else if (wcount >= WCW'(MAX_WAITERS)) begin
				res.status = fbpm_pkg::STATUS_WAITQ_FULL;
			end else begin
				fifo_addr   = {pidx, wtail};
				mem.fifo_we = 1'b1;
				tail_nx     = (wtail == WW'(MAX_WAITERS - 1)) ? '0 : wtail + WW'(1);
				count_nx    = wcount + WCW'(1);
				res.status  = fbpm_pkg::STATUS_QUEUED;
				upd         = 1'b1;
			end
		end else if (kind == fbpm_pkg::KIND_RELEASE) begin
			priority if (wcount != '0) begin
				// hand the block straight to the oldest waiter
				mem.fifo_re  = 1'b1;
				res.woken_rd = 1'b1;
				res.granted  = released_block;
				head_nx      = (whead == WW'(MAX_WAITERS - 1)) ? '0 : whead + WW'(1);
				count_nx     = wcount - WCW'(1);
				upd          = 1'b1;
			end else if (free_now >= n_x || XW'(depth) >= XW'(MAX_BLOCKS)) begin
				res.status = fbpm_pkg::STATUS_OVERFLOW;
			end else begin
				mem.stack_we = 1'b1;
				depth_nx     = depth + CW'(1);
				upd          = 1'b1;
			end
		end else begin
			res.free_count = (free_now > n_x) ? n : fbpm_pkg::COUNT_W'(free_now);
			if (wcount != '0) begin
				mem.fifo_re = 1'b1;
				res.head_rd = 1'b1;
			end
		end

		if (!accept) begin
			mem = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_POOLS; i++) begin
				depth_q[i] <= '0;
				fresh_q[i] <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (accept && init_all) begin
			for (int i = 0; i < NUM_POOLS; i++) begin
				depth_q[i] <= '0;
				fresh_q[i] <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (accept && upd) begin
			depth_q[stack_addr[PW+BW-1:BW]] <= depth_nx;
			fresh_q[stack_addr[PW+BW-1:BW]] <= fresh_nx;
			head_q[stack_addr[PW+BW-1:BW]]  <= head_nx;
			tail_q[stack_addr[PW+BW-1:BW]]  <= tail_nx;
			count_q[stack_addr[PW+BW-1:BW]] <= count_nx;
		end
	end

endmodule

[src/fixed_block_pool_manager.sv]
// Result path: decision, counter update and RAM read are registered at acceptance into s1,
// then the merged word goes into the output register, which holds while m_tready is low.
// Throughput: one request word per cycle unless m_tready stalls; kinds 5 to 7 are taken and give no word.
// Reset clears pool sizes, all pool counters and the valid flags; the stack and
// waiter RAMs are not cleared and are only read at entries written before.
module fixed_block_pool_manager #(
	parameter int NUM_POOLS   = 4,
	parameter int MAX_BLOCKS  = 64,
	parameter int MAX_WAITERS = 8,
	parameter int MAX_TASKS   = 255
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// s_tdata: pool_id[3:0], requester_task[11:4], released_block[17:12],
	// in_task_context[18], zero[23:19]
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [fbpm_pkg::IN_DATA_W-1:0]        s_tdata,
	// s_tuser: kind[2:0]
	input  logic [fbpm_pkg::KIND_W-1:0]           s_tuser,
	// m_tdata: status[2:0], granted_block[8:3], woken_task[16:9],
	// free_count[23:17], head_waiter[31:24]
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [fbpm_pkg::OUT_DATA_W-1:0]       m_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [fbpm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fbpm_pkg::CFG_W-1:0]            cfg_data
);

	localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int BW = $clog2(MAX_BLOCKS);
	localparam int WW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int STACK_DEPTH = 1 << (PW + BW);
	localparam int FIFO_DEPTH  = 1 << (PW + WW);

	logic [fbpm_pkg::NUM_CFG-1:0][fbpm_pkg::CFG_W-1:0] pool_blocks_q;

	logic                             accept;
	logic                             adv_s1;
	logic                             valid_s1;
	fbpm_pkg::item_res_t              item_s1;
	fbpm_pkg::item_res_t              res;
	fbpm_pkg::mem_ctl_t               mem;
	logic [PW+BW-1:0]                 stack_addr;
	logic [PW+WW-1:0]                 fifo_addr;
	logic [fbpm_pkg::BLOCK_W-1:0]     stack_rdata;
	logic [fbpm_pkg::TASK_W-1:0]      fifo_rdata;
	logic                             out_valid_q;
	logic [fbpm_pkg::OUT_DATA_W-1:0]  out_data_q;
	logic [fbpm_pkg::OUT_DATA_W-1:0]  out_word;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_blocks_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			pool_blocks_q[cfg_index] <= cfg_data;
		end
	end

	fbpm_ctrl #(
		.NUM_POOLS   (NUM_POOLS),
		.MAX_BLOCKS  (MAX_BLOCKS),
		.MAX_WAITERS (MAX_WAITERS),
		.MAX_TASKS   (MAX_TASKS)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.kind            (s_tuser),
		.pool_id         (s_tdata[3:0]),
		.requester_task  (s_tdata[11:4]),
		.released_block  (s_tdata[17:12]),
		.in_task_context (s_tdata[18]),
		.pool_blocks     (pool_blocks_q),
		.res             (res),
		.mem             (mem),
		.stack_addr      (stack_addr),
		.fifo_addr       (fifo_addr)
	);

	fbpm_ram #(
		.WIDTH (fbpm_pkg::BLOCK_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (mem.stack_we),
		.waddr (stack_addr),
		.wdata (s_tdata[17:12]),
		.re    (mem.stack_re),
		.raddr (stack_addr),
		.rdata (stack_rdata)
	);

	fbpm_ram #(
		.WIDTH (fbpm_pkg::TASK_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (mem.fifo_we),
		.waddr (fifo_addr),
		.wdata (s_tdata[11:4]),
		.re    (mem.fifo_re),
		.raddr (fifo_addr),
		.rdata (fifo_rdata)
	);

	// Hold the decided word while the RAM read completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= (s_tuser <= fbpm_pkg::KIND_W'(fbpm_pkg::KIND_INIT));
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= res;
		end
	end

	// Merge the RAM read data into the result word.
	always_comb begin
		out_word = {
			item_s1.head_rd  ? fifo_rdata : fbpm_pkg::TASK_W'(0),
			item_s1.free_count,
			item_s1.woken_rd ? fifo_rdata : fbpm_pkg::TASK_W'(0),
			item_s1.stack_rd ? stack_rdata : item_s1.granted,
			item_s1.status
		};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data_q <= out_word;
		end
	end

	a_unknown_kind_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser > fbpm_pkg::KIND_W'(fbpm_pkg::KIND_INIT))
		|=> !valid_s1)
		else $error("unknown kind produced a pending result");

	a_one_ram_source: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0({item_s1.stack_rd, item_s1.woken_rd, item_s1.head_rd}))
		else $error("more than one RAM source selected for one word");

	a_woken_means_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[16:9] != '0)
		|-> m_tdata[2:0] == fbpm_pkg::STATUS_W'(fbpm_pkg::STATUS_OK))
		else $error("woken task reported with a failing status");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |-> !(mem.stack_re || mem.fifo_re) ##1 valid_s1)
		else $error("pending word lost or RAM read issued during a stall");

endmodule
